// ----- src/tlsc_pkg.sv -----
package tlsc_pkg;

	typedef enum logic [5:0] {
		PH_HEADER  = 6'b000001,
		PH_TYPE    = 6'b000010,
		PH_LENGTH  = 6'b000100,
		PH_PAYLOAD = 6'b001000,
		PH_DONE    = 6'b010000,
		PH_FAILED  = 6'b100000
	} phase_t;

	localparam logic [2:0] FAULT_NONE    = 3'd0;
	localparam logic [2:0] FAULT_SHORT   = 3'd1;
	localparam logic [2:0] FAULT_TRUNC   = 3'd2;
	localparam logic [2:0] FAULT_ZERO    = 3'd3;
	localparam logic [2:0] FAULT_OVERRUN = 3'd4;
	localparam logic [2:0] FAULT_TAGS    = 3'd5;
	localparam logic [2:0] FAULT_TRAIL   = 3'd6;
	localparam logic [2:0] FAULT_LONG    = 3'd7;

	localparam logic        KIND_TAG     = 1'b0;
	localparam logic        KIND_VERDICT = 1'b1;

	localparam logic [19:0] MAX_TAGS       = 20'd1000000;
	localparam logic [24:0] MAX_FILE_BYTES = 25'd16777216;
	localparam logic [19:0] COUNT_MAX      = 20'hFFFFF;

	localparam logic [3:0]  HDR_MAGIC = 4'd0;
	localparam logic [3:0]  HDR_ORDER = 4'd1;
	localparam logic [3:0]  HDR_SIZE  = 4'd7;
	localparam logic [3:0]  HDR_LAST  = 4'd15;

	localparam logic [31:0] LE_MARK = 32'h10000000;
	localparam logic [31:0] END_TAG = 32'h0000FF00;

	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	typedef struct packed {
		logic        record_kind;
		logic        run_end;
		logic [19:0] tag_number;
		logic [31:0] tag_code;
		logic [24:0] tag_byte_offset;
		logic [24:0] payload_length;
		logic [4:0]  name_index;
		logic        file_ok;
		logic        is_big_endian;
		logic [31:0] magic_value;
		logic [31:0] size_field;
		logic [2:0]  fault_code;
	} rec_t;

	function automatic logic [31:0] swap32(input logic [31:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

	function automatic logic [4:0] name_of(input logic [31:0] t);
		logic [4:0] idx;
		case (t)
			32'h000A: idx = 5'd1;
			32'hF001: idx = 5'd2;
			32'hF002: idx = 5'd3;
			32'hF003: idx = 5'd4;
			32'hF004: idx = 5'd5;
			32'hF005: idx = 5'd6;
			32'hFF05: idx = 5'd7;
			32'hF007: idx = 5'd8;
			32'hF008: idx = 5'd9;
			32'hF009: idx = 5'd10;
			32'hF00A: idx = 5'd11;
			32'hF00B: idx = 5'd12;
			32'hF00C: idx = 5'd13;
			32'hF00D: idx = 5'd14;
			32'hF022: idx = 5'd15;
			32'hF024: idx = 5'd16;
			32'hF037: idx = 5'd17;
			32'hF103: idx = 5'd18;
			32'h0025: idx = 5'd19;
			32'h0027: idx = 5'd20;
			32'h002B: idx = 5'd21;
			32'h0001: idx = 5'd22;
			32'hF105: idx = 5'd23;
			32'h0004: idx = 5'd24;
			32'h0005: idx = 5'd25;
			32'h000C: idx = 5'd26;
			32'hFF00: idx = 5'd27;
			default:  idx = 5'd0;
		endcase
		return idx;
	endfunction

endpackage

// ----- src/tlsc_word_if.sv -----
interface tlsc_word_if;
	logic        valid;
	logic        ready;
	logic [31:0] file_word;
	logic        final_word;

	modport source (output valid, output file_word, output final_word, input ready);
	modport sink (input valid, input file_word, input final_word, output ready);
endinterface

// ----- src/tlsc_result_if.sv -----
interface tlsc_result_if;
	logic        valid;
	logic        ready;
	logic        record_kind;
	logic        run_end;
	logic [19:0] tag_number;
	logic [31:0] tag_code;
	logic [24:0] tag_byte_offset;
	logic [24:0] payload_length;
	logic [4:0]  name_index;
	logic        file_ok;
	logic        is_big_endian;
	logic [31:0] magic_value;
	logic [31:0] size_field;
	logic [2:0]  fault_code;

	modport source (
		output valid, output record_kind, output run_end, output tag_number,
		output tag_code, output tag_byte_offset, output payload_length,
		output name_index, output file_ok, output is_big_endian,
		output magic_value, output size_field, output fault_code,
		input ready
	);
	modport sink (
		input valid, input record_kind, input run_end, input tag_number,
		input tag_code, input tag_byte_offset, input payload_length,
		input name_index, input file_ok, input is_big_endian,
		input magic_value, input size_field, input fault_code,
		output ready
	);
endinterface

// ----- src/tag_length_stream_checker.sv -----
// Checks the framing of a tagged file streamed one 32-bit word per transaction (first file
// byte in the top byte, final_word on the last word). One word is taken every cycle while the
// queue has room; a word is registered, checked against the file state once the queue has
// room and its results land in a four-entry result queue. Each word gives no result, one tag
// record (on the word that finishes a tag), the file verdict (on the last word), or both in
// that order; run_end marks the last of them. Input stalls only while the queue holds more
// than two results, i.e. when the result side is held off. Tag records are final only if the
// verdict that follows has file_ok set. After the verdict the checker is back in its reset
// state for the next file.
module tag_length_stream_checker (
	input  logic          clk,
	input  logic          arst_n,
	tlsc_word_if.sink     words,
	tlsc_result_if.source results
);

	logic           room;
	logic           push0;
	logic           push1;
	tlsc_pkg::rec_t data0;
	tlsc_pkg::rec_t data1;
	tlsc_pkg::rec_t head;

	tlsc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.words  (words),
		.room   (room),
		.push0  (push0),
		.data0  (data0),
		.push1  (push1),
		.data1  (data1)
	);

	tlsc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push0     (push0),
		.data0     (data0),
		.push1     (push1),
		.data1     (data1),
		.room      (room),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.out_data  (head)
	);

	assign results.record_kind     = head.record_kind;
	assign results.run_end         = head.run_end;
	assign results.tag_number      = head.tag_number;
	assign results.tag_code        = head.tag_code;
	assign results.tag_byte_offset = head.tag_byte_offset;
	assign results.payload_length  = head.payload_length;
	assign results.name_index      = head.name_index;
	assign results.file_ok         = head.file_ok;
	assign results.is_big_endian   = head.is_big_endian;
	assign results.magic_value     = head.magic_value;
	assign results.size_field      = head.size_field;
	assign results.fault_code      = head.fault_code;

	// a verdict always closes the run of its word
	a_verdict_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.record_kind |-> results.run_end)
		else $error("verdict without run_end");

	// verdict ok flag agrees with the fault code
	a_verdict_ok: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.record_kind
			|-> (results.file_ok == (results.fault_code == tlsc_pkg::FAULT_NONE)))
		else $error("file_ok disagrees with fault_code");

	// a tag record never carries verdict fields
	a_tag_clean: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.record_kind
			|-> !results.file_ok && results.fault_code == tlsc_pkg::FAULT_NONE
				&& results.magic_value == '0)
		else $error("tag record carries verdict fields");

	// a second result in one cycle only comes with a first one
	a_push_order: assert property (@(posedge clk) disable iff (!arst_n)
		push1 |-> push0 && !data0.record_kind && data1.record_kind)
		else $error("result queue write out of order");

endmodule

// ----- src/tlsc_queue.sv -----
module tlsc_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push0,
	input  tlsc_pkg::rec_t     data0,
	input  logic               push1,
	input  tlsc_pkg::rec_t     data1,
	output logic               room,
	output logic               out_valid,
	input  logic               out_ready,
	output tlsc_pkg::rec_t     out_data
);

	localparam int CW = tlsc_pkg::QAW + 1;

	tlsc_pkg::rec_t               mem_q [tlsc_pkg::QDEPTH];
	logic [tlsc_pkg::QAW-1:0]     head_q;
	logic [tlsc_pkg::QAW-1:0]     tail_q;
	logic [CW-1:0]                count_q;
	logic                         pop;
	logic [tlsc_pkg::QAW-1:0]     tail_p1;

	assign out_valid = (count_q != '0);
	assign out_data  = mem_q[head_q];
	assign pop       = out_valid && out_ready;
	assign room      = (count_q <= CW'(tlsc_pkg::QDEPTH - 2));
	assign tail_p1   = tail_q + 1'b1;

	always_ff @(posedge clk) begin
		if (push0) begin
			mem_q[tail_q] <= data0;
		end
		if (push1) begin
			mem_q[tail_p1] <= data1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop) begin
				head_q <= head_q + 1'b1;
			end
			tail_q  <= tail_q + tlsc_pkg::QAW'({1'b0, push0}) + tlsc_pkg::QAW'({1'b0, push1});
			count_q <= count_q + CW'(push0) + CW'(push1) - CW'(pop);
		end
	end

endmodule

// ----- src/tlsc_core.sv -----
module tlsc_core (
	input  logic           clk,
	input  logic           arst_n,
	tlsc_word_if.sink      words,
	input  logic           room,
	output logic           push0,
	output tlsc_pkg::rec_t data0,
	output logic           push1,
	output tlsc_pkg::rec_t data1
);

	// input stage
	logic        valid_s1;
	logic [31:0] word_s1;
	logic        last_s1;
	logic        fire;

	// file state
	tlsc_pkg::phase_t phase_q, phase_n;
	logic [3:0]  hdr_cnt_q, hdr_cnt_n;
	logic        little_q, little_n;
	logic [31:0] magic_q, magic_n;
	logic [31:0] size_q, size_n;
	logic [31:0] type_q, type_n;
	logic [22:0] wl_q, wl_n;
	logic [24:0] pos_q, pos_n;
	logic [24:0] off_q, off_n;
	logic [19:0] tags_q, tags_n;
	logic [2:0]  fault_q, fault_n;

	logic        finish;
	logic [31:0] fixed_w;
	logic [24:0] room_bytes;
	logic [22:0] wl_dec;
	logic [2:0]  code;
	tlsc_pkg::rec_t tag_rec;
	tlsc_pkg::rec_t verdict;

	assign fire        = valid_s1 && room;
	assign words.ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (words.valid && words.ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (words.valid && words.ready) begin
			word_s1 <= words.file_word;
			last_s1 <= words.final_word;
		end
	end

	always_comb begin
		phase_n    = phase_q;
		hdr_cnt_n  = hdr_cnt_q;
		little_n   = little_q;
		magic_n    = magic_q;
		size_n     = size_q;
		type_n     = type_q;
		wl_n       = wl_q;
		pos_n      = pos_q;
		off_n      = off_q;
		tags_n     = tags_q;
		fault_n    = fault_q;
		finish     = 1'b0;
		fixed_w    = little_q ? tlsc_pkg::swap32(word_s1) : word_s1;
		room_bytes = '0;
		wl_dec     = wl_q - 23'd1;
		tag_rec    = '0;

		if (phase_q != tlsc_pkg::PH_FAILED) begin
			if (pos_q > tlsc_pkg::MAX_FILE_BYTES - 25'd4) begin
				fault_n = tlsc_pkg::FAULT_LONG;
				phase_n = tlsc_pkg::PH_FAILED;
			end else begin
				pos_n = pos_q + 25'd4;
				case (phase_q)
					tlsc_pkg::PH_HEADER: begin
						if (hdr_cnt_q == tlsc_pkg::HDR_MAGIC) magic_n = word_s1;
						if (hdr_cnt_q == tlsc_pkg::HDR_ORDER) little_n = (word_s1 == tlsc_pkg::LE_MARK);
						if (hdr_cnt_q == tlsc_pkg::HDR_SIZE) size_n = word_s1;
						if (hdr_cnt_q == tlsc_pkg::HDR_LAST) begin
							hdr_cnt_n = '0;
							phase_n   = tlsc_pkg::PH_TYPE;
						end else begin
							hdr_cnt_n = hdr_cnt_q + 4'd1;
						end
					end
					tlsc_pkg::PH_TYPE: begin
						off_n = pos_q;
						if (last_s1) begin
							fault_n = tlsc_pkg::FAULT_TRUNC;
							phase_n = tlsc_pkg::PH_FAILED;
						end else if (tags_q > tlsc_pkg::MAX_TAGS) begin
							fault_n = tlsc_pkg::FAULT_TAGS;
							phase_n = tlsc_pkg::PH_FAILED;
						end else begin
							type_n = fixed_w;
							if (fixed_w == '0) begin
								fault_n = tlsc_pkg::FAULT_ZERO;
								phase_n = tlsc_pkg::PH_FAILED;
							end else begin
								phase_n = tlsc_pkg::PH_LENGTH;
							end
						end
					end
					tlsc_pkg::PH_LENGTH: begin
						room_bytes = tlsc_pkg::MAX_FILE_BYTES - pos_n;
						if ((|fixed_w[31:23]) || ({fixed_w[22:0], 2'b00} > room_bytes)
							|| (last_s1 && fixed_w != '0)) begin
							fault_n = tlsc_pkg::FAULT_OVERRUN;
							phase_n = tlsc_pkg::PH_FAILED;
						end else begin
							wl_n = fixed_w[22:0];
							if (fixed_w == '0) begin
								finish = 1'b1;
							end else begin
								phase_n = tlsc_pkg::PH_PAYLOAD;
							end
						end
					end
					tlsc_pkg::PH_PAYLOAD: begin
						wl_n = wl_dec;
						if (wl_dec == '0) begin
							finish = 1'b1;
						end else if (last_s1) begin
							fault_n = tlsc_pkg::FAULT_OVERRUN;
							phase_n = tlsc_pkg::PH_FAILED;
						end
					end
					tlsc_pkg::PH_DONE: begin
						fault_n = tlsc_pkg::FAULT_TRAIL;
						phase_n = tlsc_pkg::PH_FAILED;
					end
					default: begin
						fault_n = tlsc_pkg::FAULT_TRUNC;
						phase_n = tlsc_pkg::PH_FAILED;
					end
				endcase
			end
		end

		if (finish) begin
			tag_rec.record_kind     = tlsc_pkg::KIND_TAG;
			tag_rec.run_end         = !last_s1;
			tag_rec.tag_number      = tags_q;
			tag_rec.tag_code        = type_q;
			tag_rec.tag_byte_offset = off_q;
			tag_rec.payload_length  = pos_n - off_q - 25'd8;
			tag_rec.name_index      = tlsc_pkg::name_of(type_q);
			if (tags_q < tlsc_pkg::COUNT_MAX) begin
				tags_n = tags_q + 20'd1;
			end
			phase_n = (type_q == tlsc_pkg::END_TAG) ? tlsc_pkg::PH_DONE : tlsc_pkg::PH_TYPE;
		end

		code = fault_n;
		if (fault_n == tlsc_pkg::FAULT_NONE) begin
			case (phase_n)
				tlsc_pkg::PH_HEADER:  code = tlsc_pkg::FAULT_SHORT;
				tlsc_pkg::PH_TYPE:    code = tlsc_pkg::FAULT_TRUNC;
				tlsc_pkg::PH_LENGTH:  code = tlsc_pkg::FAULT_OVERRUN;
				tlsc_pkg::PH_PAYLOAD: code = tlsc_pkg::FAULT_OVERRUN;
				default:              code = tlsc_pkg::FAULT_NONE;
			endcase
		end

		verdict               = '0;
		verdict.record_kind   = tlsc_pkg::KIND_VERDICT;
		verdict.run_end       = 1'b1;
		verdict.tag_number    = tags_n;
		verdict.file_ok       = (code == tlsc_pkg::FAULT_NONE);
		verdict.is_big_endian = !little_n;
		verdict.magic_value   = little_n ? tlsc_pkg::swap32(magic_n) : magic_n;
		verdict.size_field    = little_n ? tlsc_pkg::swap32(size_n) : size_n;
		verdict.fault_code    = code;
	end

	assign push0 = fire && (finish || last_s1);
	assign data0 = finish ? tag_rec : verdict;
	assign push1 = fire && finish && last_s1;
	assign data1 = verdict;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= tlsc_pkg::PH_HEADER;
			hdr_cnt_q <= '0;
			little_q  <= 1'b0;
			magic_q   <= '0;
			size_q    <= '0;
			type_q    <= '0;
			wl_q      <= '0;
			pos_q     <= '0;
			off_q     <= '0;
			tags_q    <= '0;
			fault_q   <= tlsc_pkg::FAULT_NONE;
		end else if (fire) begin
			if (last_s1) begin
				phase_q   <= tlsc_pkg::PH_HEADER;
				hdr_cnt_q <= '0;
				little_q  <= 1'b0;
				magic_q   <= '0;
				size_q    <= '0;
				type_q    <= '0;
				wl_q      <= '0;
				pos_q     <= '0;
				off_q     <= '0;
				tags_q    <= '0;
				fault_q   <= tlsc_pkg::FAULT_NONE;
			end else begin
				phase_q   <= phase_n;
				hdr_cnt_q <= hdr_cnt_n;
				little_q  <= little_n;
				magic_q   <= magic_n;
				size_q    <= size_n;
				type_q    <= type_n;
				wl_q      <= wl_n;
				pos_q     <= pos_n;
				off_q     <= off_n;
				tags_q    <= tags_n;
				fault_q   <= fault_n;
			end
		end
	end

endmodule
